// File: hdl/bhe_pkg.sv
// Shared types and constants of the Bezier Horner evaluator.
package bhe_pkg;

  localparam int CURVE_W = 4;
  localparam int COORD_W = 3;
  localparam int DEG_W   = 6;

  localparam logic [DEG_W-1:0] DEGREE_RESET    = 6'd3;
  localparam logic [DEG_W-1:0] HW_DEGREE_LIMIT = 6'd61;
  localparam logic             OPER_LOAD       = 1'b0;
  localparam logic             OPER_EVAL       = 1'b1;
  localparam logic [16:0]      Q_ONE           = 17'd65536;
  localparam logic [80:0]      TERM_CAP        = 81'd1 << 48;

  typedef enum logic [4:0] {
    OP_NONE, OP_STORE, OP_START,
    OP_BE_M0, OP_BE_M1, OP_BE_ADD, OP_BE_WR,
    OP_BN_M0, OP_BN_M1, OP_BN_ADD, OP_DIV, OP_BN_DONE,
    OP_INIT, OP_ABS, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_T6, OP_T7,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BE_M0, ST_BE_M1, ST_BE_ADD, ST_BE_WR,
    ST_BN_M0, ST_BN_M1, ST_BN_ADD, ST_DIV, ST_BN_DONE,
    ST_E_RD0, ST_E_INIT, ST_IT_RD, ST_IT_ABS,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [CURVE_W-1:0] curve;
    logic [COORD_W-1:0] coord;
    logic [DEG_W-1:0]   idx;
    logic [DEG_W-1:0]   degree;
    logic               err;
    logic               last;
  } cmd_t;

endpackage

// File: hdl/bhe_ctrl.sv
// Controller: sequences coefficient preparation, per-coordinate Horner steps and output.
module bhe_ctrl import bhe_pkg::*; #(
  parameter int MAX_DEGREE = 31,
  parameter int NUM_CURVES = 4,
  parameter int DIMENSIONS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DEG_W-1:0] cfg_curve_degree,
  input  logic             out_free,
  output cmd_t             cmd
);

  localparam int CW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
  localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  state_t           state_r, state_nxt;
  logic [DEG_W-1:0] deg_r;
  logic [DEG_W-1:0] i_r, i_nxt;
  logic [5:0]       div_r, div_nxt;
  logic [CW-1:0]    c_r, c_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic             err;
  logic             last;

  // degree changes only between evaluations
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign err  = (deg_r > HW_DEGREE_LIMIT) || (32'(deg_r) > MAX_DEGREE);
  assign last = (c_r == CW'(NUM_CURVES - 1)) && (d_r == DW'(DIMENSIONS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      deg_r   <= DEGREE_RESET;
      i_r     <= '0;
      div_r   <= '0;
      c_r     <= '0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      div_r   <= div_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      if (cfg_valid && cfg_ready) begin
        deg_r <= cfg_curve_degree;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    div_nxt    = div_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    in_ready   = (state_r == ST_IDLE);
    cmd.op     = OP_NONE;
    cmd.curve  = CURVE_W'(c_r);
    cmd.coord  = COORD_W'(d_r);
    cmd.idx    = (state_r == ST_E_RD0) ? '0 : i_r;
    cmd.degree = deg_r;
    cmd.err    = err;
    cmd.last   = last;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OPER_EVAL) begin
            cmd.op    = OP_START;
            c_nxt     = '0;
            d_nxt     = '0;
            i_nxt     = 6'd1;
            state_nxt = (err || deg_r == '0) ? ST_E_RD0 : ST_BE_M0;
          end else begin
            cmd.op = OP_STORE;
          end
        end
      end
      ST_BE_M0: begin
        cmd.op    = OP_BE_M0;
        state_nxt = ST_BE_M1;
      end
      ST_BE_M1: begin
        cmd.op    = OP_BE_M1;
        state_nxt = ST_BE_ADD;
      end
      ST_BE_ADD: begin
        cmd.op    = OP_BE_ADD;
        state_nxt = ST_BE_WR;
      end
      ST_BE_WR: begin
        cmd.op    = OP_BE_WR;
        state_nxt = (i_r == deg_r) ? ST_E_RD0 : ST_BN_M0;
      end
      ST_BN_M0: begin
        cmd.op    = OP_BN_M0;
        state_nxt = ST_BN_M1;
      end
      ST_BN_M1: begin
        cmd.op    = OP_BN_M1;
        state_nxt = ST_BN_ADD;
      end
      ST_BN_ADD: begin
        cmd.op    = OP_BN_ADD;
        div_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = OP_DIV;
        div_nxt = div_r + 6'd1;
        if (div_r == 6'd63) begin
          state_nxt = ST_BN_DONE;
        end
      end
      ST_BN_DONE: begin
        cmd.op    = OP_BN_DONE;
        i_nxt     = i_r + 6'd1;
        state_nxt = ST_BE_M0;
      end
      ST_E_RD0: begin
        state_nxt = ST_E_INIT;
      end
      ST_E_INIT: begin
        cmd.op = OP_INIT;
        if (err || deg_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          i_nxt     = 6'd1;
          state_nxt = ST_IT_RD;
        end
      end
      ST_IT_RD: begin
        state_nxt = ST_IT_ABS;
      end
      ST_IT_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        cmd.op    = OP_T1;
        state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd.op    = OP_T2;
        state_nxt = ST_T3;
      end
      ST_T3: begin
        cmd.op    = OP_T3;
        state_nxt = ST_T4;
      end
      ST_T4: begin
        cmd.op    = OP_T4;
        state_nxt = ST_T5;
      end
      ST_T5: begin
        cmd.op    = OP_T5;
        state_nxt = ST_T6;
      end
      ST_T6: begin
        cmd.op    = OP_T6;
        state_nxt = ST_T7;
      end
      ST_T7: begin
        cmd.op = OP_T7;
        if (i_r == deg_r) begin
          state_nxt = ST_EMIT;
        end else begin
          i_nxt     = i_r + 6'd1;
          state_nxt = ST_IT_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.op = OP_EMIT;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_E_RD0;
            if (d_r == DW'(DIMENSIONS - 1)) begin
              d_nxt = '0;
              c_nxt = c_r + CW'(1);
            end else begin
              d_nxt = d_r + DW'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> out_free) else $error("emit into full output register");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> i_r < deg_r) else $error("coefficient update past degree");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT && cmd.last) |=> state_r == ST_IDLE)
    else $error("evaluation not finished after last result");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IT_ABS |-> (i_r != '0 && i_r <= deg_r && !err))
    else $error("Horner step index out of range");

endmodule

// File: hdl/bhe_datapath.sv
// Datapath: control store, coefficient table, shared multiplier, divider and output register.
module bhe_datapath import bhe_pkg::*; #(
  parameter int MAX_DEGREE = 31,
  parameter int NUM_CURVES = 4,
  parameter int DIMENSIONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [1:0]         in_curve_index,
  input  logic [4:0]         in_point_index,
  input  logic [1:0]         in_coord_index,
  input  logic signed [31:0] in_coord_value,
  input  logic [16:0]        in_param_t,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_curve,
  output logic [1:0]         out_coord,
  output logic signed [31:0] out_point_value,
  output logic               out_degree_error,
  output logic               out_last
);

  localparam int NPTS   = MAX_DEGREE + 1;
  localparam int DEPTH  = NUM_CURVES * NPTS * DIMENSIONS;
  localparam int AW     = $clog2(DEPTH);
  localparam int TDEPTH = MAX_DEGREE;
  localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam logic signed [51:0] ACC_MAX = 52'sh7FFF_FFFF_FFFF;
  localparam logic signed [51:0] ACC_MIN = -52'sh8000_0000_0000;

  logic [31:0] store_mem [DEPTH];
  logic [63:0] tab_mem [TDEPTH];
  logic [31:0] store_q_r;
  logic [63:0] tab_q_r;

  logic [AW-1:0] wr_addr, rd_addr;
  logic [TW-1:0] tab_addr;
  logic          wr_ok;

  logic [16:0]        t_r, s_r, pw_r, t_eff;
  logic [63:0]        binom_r, mul_r, be_r, mul_p;
  logic [31:0]        mul_a, mul_b, pm_r, rnd_r;
  logic [80:0]        big_r;
  logic [5:0]         rem_r, k_val;
  logic [6:0]         div_tmp, div_d;
  logic               div_ge;
  logic signed [47:0] acc_r, acc_sat;
  logic [47:0]        am_r, scl;
  logic               pneg_r, aneg_r, cap_r;
  logic [49:0]        term_r;
  logic [64:0]        sc_r;
  logic signed [51:0] sv, tv, sum;
  logic signed [31:0] val32;
  logic               out_valid_r;

  assign wr_addr  = AW'((32'(in_curve_index) * NPTS + 32'(in_point_index)) * DIMENSIONS
                        + 32'(in_coord_index));
  assign rd_addr  = AW'((32'(cmd.curve) * NPTS + 32'(cmd.idx)) * DIMENSIONS
                        + 32'(cmd.coord));
  assign tab_addr = TW'(cmd.idx - 6'd1);
  assign wr_ok    = (32'(in_curve_index) < NUM_CURVES) && (32'(in_coord_index) < DIMENSIONS)
                    && (32'(in_point_index) <= MAX_DEGREE);
  assign t_eff    = (in_param_t > Q_ONE) ? Q_ONE : in_param_t;
  assign k_val    = cmd.degree - cmd.idx;
  assign div_tmp  = {rem_r, big_r[63]};
  assign div_d    = {1'b0, cmd.idx} + 7'd1;
  assign div_ge   = div_tmp >= div_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_BE_M0:  begin mul_a = binom_r[31:0];       mul_b = 32'(pw_r); end
      OP_BE_M1:  begin mul_a = binom_r[63:32];      mul_b = 32'(pw_r); end
      OP_BE_ADD: begin mul_a = 32'(pw_r);           mul_b = 32'(t_r);  end
      OP_BN_M0:  begin mul_a = binom_r[31:0];       mul_b = 32'(k_val); end
      OP_BN_M1:  begin mul_a = binom_r[63:32];      mul_b = 32'(k_val); end
      OP_T1:     begin mul_a = be_r[47:16];         mul_b = pm_r; end
      OP_T2:     begin mul_a = 32'(be_r[63:48]);    mul_b = pm_r; end
      OP_T3:     begin mul_a = 32'(be_r[15:0]);     mul_b = pm_r; end
      OP_T4:     begin mul_a = am_r[31:0];          mul_b = 32'(s_r); end
      OP_T5:     begin mul_a = 32'(am_r[47:32]);    mul_b = 32'(s_r); end
      default:   begin mul_a = '0;                  mul_b = '0; end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    scl = sc_r[63:16];
    sv  = aneg_r ? -$signed({4'b0, scl}) : $signed({4'b0, scl});
    tv  = pneg_r ? -$signed({2'b0, term_r}) : $signed({2'b0, term_r});
    sum = sv + tv;
    if (sum > ACC_MAX) begin
      acc_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (sum < ACC_MIN) begin
      acc_sat = 48'sh8000_0000_0000;
    end else begin
      acc_sat = sum[47:0];
    end
    if (acc_r > 48'sh0000_7FFF_FFFF) begin
      val32 = 32'sh7FFF_FFFF;
    end else if (acc_r < -48'sh0000_8000_0000) begin
      val32 = 32'sh8000_0000;
    end else begin
      val32 = acc_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    store_q_r <= store_mem[rd_addr];
    tab_q_r   <= tab_mem[tab_addr];
    if (cmd.op == OP_STORE && wr_ok) begin
      store_mem[wr_addr] <= in_coord_value;
    end
    if (cmd.op == OP_BE_WR) begin
      tab_mem[tab_addr] <= (|big_r[80:64]) ? '1 : big_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    case (cmd.op)
      OP_START: begin
        t_r     <= t_eff;
        s_r     <= Q_ONE - t_eff;
        pw_r    <= t_eff;
        binom_r <= 64'(cmd.degree);
      end
      OP_BE_M1:   big_r <= 81'(mul_r);
      OP_BE_ADD:  big_r <= big_r + (81'(mul_r) << 32);
      OP_BE_WR:   pw_r  <= 17'((mul_r + 64'd32768) >> 16);
      OP_BN_M1:   big_r <= 81'(mul_r);
      OP_BN_ADD: begin
        big_r <= 81'(big_r[63:0] + {mul_r[31:0], 32'b0});
        rem_r <= '0;
      end
      OP_DIV: begin
        rem_r         <= div_ge ? 6'(div_tmp - div_d) : div_tmp[5:0];
        big_r[63:0]   <= {big_r[62:0], div_ge};
      end
      OP_BN_DONE: binom_r <= big_r[63:0];
      OP_INIT:    acc_r   <= 48'($signed(store_q_r));
      OP_ABS: begin
        pneg_r <= store_q_r[31];
        pm_r   <= store_q_r[31] ? -store_q_r : store_q_r;
        aneg_r <= acc_r[47];
        am_r   <= acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
        be_r   <= tab_q_r;
      end
      OP_T2: big_r <= 81'(mul_r);
      OP_T3: big_r <= big_r + (81'(mul_r) << 32);
      OP_T4: begin
        rnd_r <= 32'((mul_r + 64'd32768) >> 16);
        cap_r <= big_r > TERM_CAP;
      end
      OP_T5: begin
        term_r <= cap_r ? 50'(TERM_CAP) : 50'(big_r) + 50'(rnd_r);
        sc_r   <= 65'(mul_r);
      end
      OP_T6: sc_r  <= sc_r + (65'(mul_r) << 32) + 65'd32768;
      OP_T7: acc_r <= acc_sat;
      OP_EMIT: begin
        out_curve        <= 2'(cmd.curve);
        out_coord        <= 2'(cmd.coord);
        out_point_value  <= val32;
        out_degree_error <= cmd.err;
        out_last         <= cmd.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

endmodule

// File: hdl/bezier_horner_evaluator.sv
// Bezier curve evaluator, Horner scheme in fixed point: top level.
// Load request: written in idle. Evaluate request of degree n: first builds the
// C(n,i)*t^i table (64-step restoring divider per coefficient), then computes each
// result through one shared 32x32 multiplier; unsupported degree or n = 0: Horner steps skipped.
// Results = NUM_CURVES*DIMENSIONS per evaluation, output register decouples the result side.
// Synchronous reset: idle, degree register 3; control store holds no reset value.
module bezier_horner_evaluator import bhe_pkg::*; #(
  parameter int MAX_DEGREE = 31,
  parameter int NUM_CURVES = 4,
  parameter int DIMENSIONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [1:0]         in_curve_index,
  input  logic [4:0]         in_point_index,
  input  logic [1:0]         in_coord_index,
  input  logic signed [31:0] in_coord_value,
  input  logic [16:0]        in_param_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_curve,
  output logic [1:0]         out_coord,
  output logic signed [31:0] out_point_value,
  output logic               out_degree_error,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_curve_degree
);

  cmd_t cmd;
  logic out_free;

  bhe_ctrl #(
    .MAX_DEGREE(MAX_DEGREE),
    .NUM_CURVES(NUM_CURVES),
    .DIMENSIONS(DIMENSIONS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_curve_degree (cfg_curve_degree),
    .out_free         (out_free),
    .cmd              (cmd)
  );

  bhe_datapath #(
    .MAX_DEGREE(MAX_DEGREE),
    .NUM_CURVES(NUM_CURVES),
    .DIMENSIONS(DIMENSIONS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_curve_index   (in_curve_index),
    .in_point_index   (in_point_index),
    .in_coord_index   (in_coord_index),
    .in_coord_value   (in_coord_value),
    .in_param_t       (in_param_t),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_curve        (out_curve),
    .out_coord        (out_coord),
    .out_point_value  (out_point_value),
    .out_degree_error (out_degree_error),
    .out_last         (out_last)
  );

endmodule

// File: dv/bezier_horner_evaluator_tb.sv
// Testbench for bezier_horner_evaluator: directed and random loads and evaluations checked against a predictor.
module bezier_horner_evaluator_tb;
  import bhe_pkg::*;

  typedef struct {
    logic              op;
    logic [1:0]        curve;
    logic [4:0]        point;
    logic [1:0]        coord;
    logic [31:0]       value;
    logic [16:0]       t;
  } request_t;

  typedef struct {
    logic [1:0]  curve;
    logic [1:0]  coord;
    logic [31:0] value;
    logic        err;
    logic        last;
  } result_t;

  localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint unsigned CAP = 64'd1 << 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [1:0] in_curve_index = '0;
  logic [4:0] in_point_index = '0;
  logic [1:0] in_coord_index = '0;
  logic signed [31:0] in_coord_value = '0;
  logic [16:0] in_param_t = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_curve;
  logic [1:0] out_coord;
  logic signed [31:0] out_point_value;
  logic out_degree_error;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_curve_degree = '0;

  request_t pending_reqs[$];
  result_t  expected_points[$];
  logic [31:0] ctrl_pts[4][32][4];
  logic [5:0] degree_shadow = DEGREE_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int errors = 0;
  bit in_fire;

  bezier_horner_evaluator dut (.*);

  always #10 clk = ~clk;

  function automatic longint scale_by_one_minus_t(longint acc, longint unsigned s);
    longint unsigned mag;
    longint unsigned m;
    mag = acc < 0 ? longint'(-acc) : acc;
    m = (mag * s + 32768) >> 16;
    return acc < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint bern_term(longint unsigned binom, longint unsigned e, longint p);
    longint unsigned pm, be, hi, lo, m;
    pm = p < 0 ? longint'(-p) : p;
    if (e != 0 && binom > 64'hFFFF_FFFF_FFFF_FFFF / e) be = 64'hFFFF_FFFF_FFFF_FFFF;
    else be = binom * e;
    hi = be >> 16;
    lo = be & 64'hFFFF;
    if (hi != 0 && pm > CAP / hi) m = CAP;
    else m = hi * pm + ((lo * pm + 32768) >> 16);
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_curves(request_t r);
    longint acc[4][4];
    longint unsigned t, s, binom, pw;
    longint v;
    int n;
    bit err;
    result_t res;
    t = r.t > Q_ONE ? Q_ONE : r.t;
    s = Q_ONE - t;
    n = degree_shadow;
    err = n > HW_DEGREE_LIMIT || n > 31;
    for (int c = 0; c < 4; c++)
      for (int d = 0; d < 4; d++)
        acc[c][d] = longint'(signed'(ctrl_pts[c][0][d]));
    if (!err) begin
      binom = n;
      pw = t;
      for (int i = 1; i <= n; i++) begin
        for (int c = 0; c < 4; c++)
          for (int d = 0; d < 4; d++) begin
            v = scale_by_one_minus_t(acc[c][d], s) +
                bern_term(binom, pw, longint'(signed'(ctrl_pts[c][i][d])));
            acc[c][d] = v > ACC_MAX ? ACC_MAX : (v < ACC_MIN ? ACC_MIN : v);
          end
        pw = (pw * t + 32768) >> 16;
        binom = binom * longint'(n - i) / longint'(i + 1);
      end
    end
    for (int c = 0; c < 4; c++)
      for (int d = 0; d < 4; d++) begin
        v = acc[c][d];
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        res.curve = 2'(c);
        res.coord = 2'(d);
        res.value = v[31:0];
        res.err = err;
        res.last = (c == 3 && d == 3);
        expected_points.push_back(res);
      end
  endtask

  // accept side: update the store or predict results
  always @(posedge clk) begin
    in_fire = in_valid && in_ready;
    if (in_fire) begin
      if (in_operation == OPER_LOAD)
        ctrl_pts[in_curve_index][in_point_index][in_coord_index] = in_coord_value;
      else
        predict_curves('{in_operation, in_curve_index, in_point_index, in_coord_index,
                         in_coord_value, in_param_t});
    end
  end

  always @(negedge clk) begin
    request_t r;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_operation <= r.op;
        in_curve_index <= r.curve;
        in_point_index <= r.point;
        in_coord_index <= r.coord;
        in_coord_value <= r.value;
        in_param_t <= r.t;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
    out_ready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    result_t e;
    if (out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result curve %0d coord %0d", out_curve, out_coord);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_curve !== e.curve) begin
          $error("out_curve exp %0d got %0d", e.curve, out_curve); errors++;
        end
        if (out_coord !== e.coord) begin
          $error("out_coord exp %0d got %0d", e.coord, out_coord); errors++;
        end
        if (out_point_value !== e.value) begin
          $error("point_value exp %h got %h", e.value, out_point_value); errors++;
        end
        if (out_degree_error !== e.err) begin
          $error("degree_error exp %0d got %0d", e.err, out_degree_error); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t mk_load(int c, int p, int d, logic [31:0] v);
    request_t r;
    r = '{OPER_LOAD, 2'(c), 5'(p), 2'(d), v, 17'($urandom)};
    return r;
  endfunction

  function automatic request_t mk_eval(logic [16:0] t);
    request_t r;
    r = '{OPER_EVAL, 2'($urandom), 5'($urandom), 2'($urandom), $urandom, t};
    return r;
  endfunction

  function automatic logic [16:0] pick_t();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return Q_ONE;
      2: return 17'($urandom_range(17'h1FFFF, 17'd65537));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_points.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_degree(logic [5:0] deg);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_curve_degree <= deg;
    do @(posedge clk); while (!cfg_ready);
    degree_shadow = deg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int nreq, int max_deg, int sidle, int rstall);
    set_degree(6'($urandom_range(max_deg, 1)));
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < nreq; k++) begin
      if ($urandom_range(99) < 15) pending_reqs.push_back(mk_eval(pick_t()));
      else pending_reqs.push_back(mk_load($urandom, $urandom_range(max_deg), $urandom,
                                          pick_value()));
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // fill every point up to the highest degree evaluated below
    for (int c = 0; c < 4; c++)
      for (int p = 0; p < 16; p++)
        for (int d = 0; d < 4; d++)
          pending_reqs.push_back(mk_load(c, p, d, pick_value()));
    pending_reqs.push_back(mk_eval(17'd0));
    pending_reqs.push_back(mk_eval(Q_ONE));
    pending_reqs.push_back(mk_eval(17'h1FFFF));
    pending_reqs.push_back(mk_eval(17'd32768));
    pending_reqs.push_back(mk_eval(17'd1));
    pending_reqs.push_back(mk_load(0, 1, 0, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk_load(0, 2, 0, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk_load(1, 1, 3, 32'h8000_0000));
    pending_reqs.push_back(mk_load(1, 2, 3, 32'h8000_0000));
    pending_reqs.push_back(mk_load(3, 0, 3, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_eval(17'd40000));
    pending_reqs.push_back(mk_eval(17'd65535));
    drain();
    set_degree(6'd0);
    pending_reqs.push_back(mk_eval(17'd12345));
    drain();
    set_degree(6'd63);
    pending_reqs.push_back(mk_eval(17'd30000));
    drain();
    set_degree(6'd32);
    pending_reqs.push_back(mk_eval(Q_ONE));
    drain();
    set_degree(6'd15);
    pending_reqs.push_back(mk_eval(17'd33000));
    pending_reqs.push_back(mk_eval(17'h1FFFF));
    drain();
    set_degree(6'd1);
    for (int k = 0; k < 6; k++) pending_reqs.push_back(mk_eval(pick_t()));
    hold_reqs++;
    drain();
    random_phase(35, 5, 0, 0);
    random_phase(35, 4, 73, 0);
    random_phase(35, 4, 0, 73);
    random_phase(35, 6, 10, 10);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
